// ===== hdl/gcgb_pkg.sv =====
// Shared types, constants and table builders for the glyph blend block.
`default_nettype none

package gcgb_pkg;

  // Clamp for surface size
  localparam int MAX_SURFACE_DIM   = 4096;
  // Entries of the linear-to-sRGB mapping (index is 12 bits)
  localparam int LINEAR_TABLE_SIZE = 4096;
  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH       = 4;
  // One output bit resolved per search stage
  localparam int SRCH_STEPS        = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [7:0]  COV_NONE     = 8'h00;
  localparam logic [7:0]  COV_FULL     = 8'hFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [15:0] LIN_MAX      = 16'hFFFF;

  localparam logic [8:0] GLYPH_COLS_RST = 9'd8;
  localparam logic [8:0] GLYPH_ROWS_RST = 9'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_GLYPH_COLS   = 3'd2,
    CFG_GLYPH_ROWS   = 3'd3,
    CFG_SURFACE_COLS = 3'd4,
    CFG_SURFACE_ROWS = 3'd5,
    CFG_ROW_PITCH    = 3'd6,
    CFG_TEXT_RGB     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  coverage;
    logic [31:0] background_pixel;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [24:0] pixel_address;
    logic [31:0] new_pixel;
    logic        glyph_done;
  } out_item_t;

  // Classified element handed from front to back
  typedef struct packed {
    logic        write_enable;
    logic        full_cover;
    logic [7:0]  coverage;
    logic [23:0] bg_rgb;
    logic [24:0] pixel_address;
    logic        glyph_done;
  } job_t;

  typedef logic [255:0][11:0] thr_tab_t;

  // Entry m: smallest linear index whose sRGB value is at least m
  // (round half up of 255*sqrt(j/4095)); entry 0 is zero.
  function automatic thr_tab_t build_srgb_thr();
    thr_tab_t tab;
    longint   odd;
    tab = '0;
    for (int m = 1; m < 256; m++) begin
      odd    = longint'(2 * m - 1);
      tab[m] = 12'((odd * odd * 4095 + 260099) / 260100);
    end
    return tab;
  endfunction

  localparam thr_tab_t SRGB_THR = build_srgb_thr();

  // sRGB byte to 16-bit linear, ends pinned to zero and full scale
  function automatic logic [15:0] to_linear(input logic [7:0] c);
    logic [31:0] sq;
    logic [15:0] res;
    sq = 32'(c) * 32'(c) * 32'd257 + 32'd128;
    if (c == COV_NONE) begin
      res = 16'd0;
    end else if (c == COV_FULL) begin
      res = LIN_MAX;
    end else begin
      res = sq[23:8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gcgb_stream_if.sv =====
// Valid/ready stream interface carrying one payload item per transfer.
`default_nettype none

interface gcgb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/gcgb_front.sv =====
// Front end: config registers, glyph position counters, clipping and address.
`default_nettype none

module gcgb_front #(
  parameter int MAX_GLYPH_SIZE = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gcgb_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [gcgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcgb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                job_valid,
  input  logic                                job_ready,
  output gcgb_pkg::job_t                      job,
  output logic [23:0]                         text_rgb
);

  localparam int          CNT_W     = (MAX_GLYPH_SIZE > 1) ? $clog2(MAX_GLYPH_SIZE) : 1;
  localparam logic [11:0] GLYPH_MAX = 12'(MAX_GLYPH_SIZE);
  localparam logic [12:0] SURF_MAX  = 13'(gcgb_pkg::MAX_SURFACE_DIM);

  logic [12:0] origin_x_r, origin_y_r;
  logic [8:0]  glyph_cols_r, glyph_rows_r;
  logic [12:0] surface_cols_r, surface_rows_r;
  logic [13:0] row_pitch_r;
  logic [23:0] text_rgb_r;

  logic [CNT_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [11:0]      cols_lim, rows_lim;
  logic             last_col, last_row, in_fire;

  logic        f1_valid_r;
  logic [7:0]  f1_cov_r;
  logic [23:0] f1_bg_r;
  logic [13:0] f1_px_r, f1_py_r;
  logic        f1_done_r;

  logic [12:0] scols_lim, srows_lim;
  logic        on_surface, write_en;
  logic [26:0] addr_full;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      glyph_cols_r   <= gcgb_pkg::GLYPH_COLS_RST;
      glyph_rows_r   <= gcgb_pkg::GLYPH_ROWS_RST;
      surface_cols_r <= '0;
      surface_rows_r <= '0;
      row_pitch_r    <= '0;
      text_rgb_r     <= '0;
    end else if (cfg_we) begin
      case (gcgb_pkg::cfg_idx_t'(cfg_index))
        gcgb_pkg::CFG_ORIGIN_X:     origin_x_r     <= cfg_wdata[12:0];
        gcgb_pkg::CFG_ORIGIN_Y:     origin_y_r     <= cfg_wdata[12:0];
        gcgb_pkg::CFG_GLYPH_COLS:   glyph_cols_r   <= cfg_wdata[8:0];
        gcgb_pkg::CFG_GLYPH_ROWS:   glyph_rows_r   <= cfg_wdata[8:0];
        gcgb_pkg::CFG_SURFACE_COLS: surface_cols_r <= cfg_wdata[12:0];
        gcgb_pkg::CFG_SURFACE_ROWS: surface_rows_r <= cfg_wdata[12:0];
        gcgb_pkg::CFG_ROW_PITCH:    row_pitch_r    <= cfg_wdata[13:0];
        gcgb_pkg::CFG_TEXT_RGB:     text_rgb_r     <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign text_rgb = text_rgb_r;

  // Glyph size clamped to 1..max
  always_comb begin
    cols_lim = 12'(glyph_cols_r);
    rows_lim = 12'(glyph_rows_r);
    if (cols_lim == 12'd0) begin
      cols_lim = 12'd1;
    end else if (cols_lim > GLYPH_MAX) begin
      cols_lim = GLYPH_MAX;
    end
    if (rows_lim == 12'd0) begin
      rows_lim = 12'd1;
    end else if (rows_lim > GLYPH_MAX) begin
      rows_lim = GLYPH_MAX;
    end
  end

  assign in_ready = !f1_valid_r || job_ready;
  assign in_fire  = in_valid && in_ready;
  assign last_col = (12'(col_r) + 12'd1) >= cols_lim;
  assign last_row = (12'(row_r) + 12'd1) >= rows_lim;

  // Raster position step
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire) begin
        f1_valid_r <= 1'b1;
      end else if (job_ready) begin
        f1_valid_r <= 1'b0;
      end
    end
  end

  // Surface position of the accepted element
  always_ff @(posedge clk) begin
    if (in_fire) begin
      f1_cov_r  <= in_item.coverage;
      f1_bg_r   <= in_item.background_pixel[23:0];
      f1_px_r   <= {origin_x_r[12], origin_x_r} + 14'(col_r);
      f1_py_r   <= {origin_y_r[12], origin_y_r} + 14'(row_r);
      f1_done_r <= last_col && last_row;
    end
  end

  // Clip and address
  assign scols_lim  = (surface_cols_r > SURF_MAX) ? SURF_MAX : surface_cols_r;
  assign srows_lim  = (surface_rows_r > SURF_MAX) ? SURF_MAX : surface_rows_r;
  assign on_surface = !f1_px_r[13] && !f1_py_r[13] &&
                      (f1_px_r[12:0] < scols_lim) && (f1_py_r[12:0] < srows_lim);
  assign write_en   = on_surface && (f1_cov_r != gcgb_pkg::COV_NONE);
  assign addr_full  = 27'(f1_py_r[12:0]) * 27'(row_pitch_r) + 27'(f1_px_r[12:0]);

  assign job_valid = f1_valid_r;
  always_comb begin
    job.write_enable  = write_en;
    job.full_cover    = f1_cov_r == gcgb_pkg::COV_FULL;
    job.coverage      = f1_cov_r;
    job.bg_rgb        = f1_bg_r;
    job.pixel_address = write_en ? addr_full[24:0] : 25'd0;
    job.glyph_done    = f1_done_r;
  end

`ifndef SYNTHESIS
  // A held element keeps its position while the queue is full
  a_f1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f1_valid_r && !job_ready |=> f1_valid_r && $stable(f1_px_r) && $stable(f1_py_r))
    else $error("front stage lost a held element");
  // Last element of a glyph leaves both counters at the origin
  a_glyph_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_col && last_row |=> col_r == '0 && row_r == '0 && f1_done_r)
    else $error("counters did not wrap at glyph end");
`endif

endmodule

`default_nettype wire

// ===== hdl/gcgb_queue.sv =====
// Short job queue decoupling the front end from the blend pipeline.
`default_nettype none

module gcgb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  gcgb_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gcgb_pkg::job_t pop_job
);

  localparam int PTR_W = $clog2(gcgb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(gcgb_pkg::QUEUE_DEPTH + 1);

  gcgb_pkg::job_t   mem_r [gcgb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(gcgb_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(gcgb_pkg::QUEUE_DEPTH))
    else $error("queue fill level past depth");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue fill level did not track a lone push");
`endif

endmodule

`default_nettype wire

// ===== hdl/gcgb_back.sv =====
// Back end: linearize, blend, divide by 255 and map back to sRGB by search.
`default_nettype none

module gcgb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  gcgb_pkg::job_t      job,
  input  logic [23:0]         text_rgb,
  output logic                out_valid,
  input  logic                out_ready,
  output gcgb_pkg::out_item_t out_item
);

  localparam int NS = gcgb_pkg::SRCH_STEPS;

  typedef struct packed {
    logic        write_enable;
    logic        full_cover;
    logic [24:0] pixel_address;
    logic        glyph_done;
  } side_t;

  logic pipe_en;

  logic                  s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  side_t                 s0_side_r, s1_side_r, s2_side_r, s3_side_r;
  logic [7:0]            s0_cov_r;
  logic [2:0][15:0]      s0_lt_r, s0_lb_r;
  logic [2:0][23:0]      s1_num_r, s2_num_r;
  logic [2:0][15:0]      s2_q_r;
  logic [2:0][11:0]      s3_idx_r;

  logic [NS-1:0]              sr_v_r;
  side_t                      sr_side_r [NS];
  logic [NS-1:0][2:0][7:0]    sr_m_r, sr_m_nxt;
  logic [NS-1:0][2:0][11:0]   sr_j_r, sr_j_nxt;

  logic                out_valid_r;
  gcgb_pkg::out_item_t out_item_r;

  logic [2:0][23:0] q_sum;
  logic [2:0][24:0] q_rem;
  logic [2:0][15:0] mix;

  // Whole pipeline moves unless the result register is held
  assign pipe_en   = !out_valid_r || out_ready;
  assign job_ready = pipe_en;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      sr_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s0_v_r      <= job_valid;
      s1_v_r      <= s0_v_r;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      sr_v_r      <= {sr_v_r[NS-2:0], s3_v_r};
      out_valid_r <= sr_v_r[NS-1];
    end
  end

  // Divide-by-255 estimate and one-step correction
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_sum[c] = s1_num_r[c] + {8'd0, s1_num_r[c][23:8]} + {16'd0, s1_num_r[c][23:16]};
      q_rem[c] = {1'b0, s2_num_r[c]} - {1'b0, s2_q_r[c], 8'd0} + 25'(s2_q_r[c]);
      mix[c]   = s2_q_r[c] + 16'(q_rem[c] >= 25'd255);
    end
  end

  // Search stages: each settles one bit of the sRGB code
  always_comb begin
    logic [7:0]  m_in, cand;
    logic [11:0] j_in;
    for (int k = 0; k < NS; k++) begin
      for (int c = 0; c < 3; c++) begin
        m_in           = (k == 0) ? 8'd0 : sr_m_r[(k == 0) ? 0 : k - 1][c];
        j_in           = (k == 0) ? s3_idx_r[c] : sr_j_r[(k == 0) ? 0 : k - 1][c];
        cand           = m_in | 8'(8'd1 << (NS - 1 - k));
        sr_m_nxt[k][c] = (gcgb_pkg::SRGB_THR[cand] <= j_in) ? cand : m_in;
        sr_j_nxt[k][c] = j_in;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // linearize
      s0_cov_r                <= job.coverage;
      s0_side_r.write_enable  <= job.write_enable;
      s0_side_r.full_cover    <= job.full_cover;
      s0_side_r.pixel_address <= job.pixel_address;
      s0_side_r.glyph_done    <= job.glyph_done;
      for (int c = 0; c < 3; c++) begin
        s0_lt_r[c] <= gcgb_pkg::to_linear(text_rgb[8*c +: 8]);
        s0_lb_r[c] <= gcgb_pkg::to_linear(job.bg_rgb[8*c +: 8]);
      end
      // weighted sum
      s1_side_r <= s0_side_r;
      for (int c = 0; c < 3; c++) begin
        s1_num_r[c] <= 24'(s0_lt_r[c]) * 24'(s0_cov_r) +
                       24'(s0_lb_r[c]) * 24'(gcgb_pkg::COV_FULL - s0_cov_r);
      end
      // quotient estimate
      s2_side_r <= s1_side_r;
      for (int c = 0; c < 3; c++) begin
        s2_q_r[c]   <= q_sum[c][23:8];
        s2_num_r[c] <= s1_num_r[c];
      end
      // corrected quotient to table index
      s3_side_r <= s2_side_r;
      for (int c = 0; c < 3; c++) begin
        s3_idx_r[c] <= mix[c][15:4];
      end
      // search
      sr_side_r[0] <= s3_side_r;
      for (int k = 1; k < NS; k++) begin
        sr_side_r[k] <= sr_side_r[k-1];
      end
      sr_m_r <= sr_m_nxt;
      sr_j_r <= sr_j_nxt;
      // result
      out_item_r.write_enable  <= sr_side_r[NS-1].write_enable;
      out_item_r.pixel_address <= sr_side_r[NS-1].pixel_address;
      out_item_r.glyph_done    <= sr_side_r[NS-1].glyph_done;
      if (!sr_side_r[NS-1].write_enable) begin
        out_item_r.new_pixel <= 32'd0;
      end else if (sr_side_r[NS-1].full_cover) begin
        out_item_r.new_pixel <= {gcgb_pkg::ALPHA_OPAQUE, text_rgb};
      end else begin
        out_item_r.new_pixel <= {gcgb_pkg::ALPHA_OPAQUE, sr_m_r[NS-1][2],
                                 sr_m_r[NS-1][1], sr_m_r[NS-1][0]};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.write_enable |->
      out_item_r.pixel_address == 25'd0 && out_item_r.new_pixel == 32'd0)
    else $error("result without write carries address or pixel");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(sr_v_r) && $stable(s0_v_r) && $stable(s3_v_r))
    else $error("blend pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/gamma_correct_glyph_blend.sv =====
// Top level: gamma-correct glyph blending, front end, job queue and blend pipeline.
// Registers from input transfer to result valid: 1 front stage, 1 queue write,
//   4 blend stages, 8 sRGB search stages and the result register.
// Throughput: one element per cycle while nothing stalls, set by the position counter
//   and the fully pipelined blend path; result back-pressure holds the whole path.
// Reset: synchronous, clears counters, queue and pipeline and loads config defaults.
`default_nettype none

module gamma_correct_glyph_blend #(
  parameter int MAX_GLYPH_SIZE = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gcgb_stream_if.sink                     in_chan,
  gcgb_stream_if.source                   out_chan,
  input  logic                            cfg_we,
  input  logic [gcgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcgb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gcgb_pkg::job_t fq_job, qb_job;
  logic           fq_valid, fq_ready, qb_valid, qb_ready;
  logic [23:0]    text_rgb;

  gcgb_front #(
    .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_chan.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job),
    .text_rgb  (text_rgb)
  );

  gcgb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  gcgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .text_rgb  (text_rgb),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_chan.data)
  );

endmodule

`default_nettype wire

// ===== bench/gamma_correct_glyph_blend_tb.sv =====
// Self-checking testbench for the gamma-correct glyph blend block.
module gamma_correct_glyph_blend_tb;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int PIPE_LATENCY   = 14;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int GLYPH_MAX      = 256;
  localparam int PHASE_ITEMS    = 300;
  localparam int LUT_SIZE       = gcgb_pkg::LINEAR_TABLE_SIZE;

  // Raw register images, at the register widths
  typedef struct {
    logic [12:0] origin_x;
    logic [12:0] origin_y;
    logic [8:0]  glyph_cols;
    logic [8:0]  glyph_rows;
    logic [12:0] surface_cols;
    logic [12:0] surface_rows;
    logic [13:0] row_pitch;
    logic [23:0] text_rgb;
  } glyph_cfg_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [gcgb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gcgb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gcgb_stream_if #(.payload_t(gcgb_pkg::in_item_t))  in_if ();
  gcgb_stream_if #(.payload_t(gcgb_pkg::out_item_t)) out_if ();

  gamma_correct_glyph_blend i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: register copy, position counters, linear-to-sRGB table
  glyph_cfg_t cur_cfg;
  int         col_cnt;
  int         row_cnt;
  logic [7:0] srgb_lut [LUT_SIZE];

  gcgb_pkg::out_item_t expected_px [$];
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  n_sent;
  int                  n_accepted;
  int                  n_writes;
  int                  n_glyphs;
  int                  n_cfg;
  int                  n_mismatch;

  always #HALF_PERIOD clk = ~clk;

  // Result-side backpressure, changed on the falling edge
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // round(255*sqrt(j/4095)) with halves rounded up; threshold grows with j
  task automatic build_srgb_lut();
    int     k;
    longint odd;
    k = 0;
    for (int j = 0; j < LUT_SIZE; j++) begin
      odd = longint'(2 * k + 1);
      while (k < 255 && odd * odd * 4095 <= longint'(260100) * j) begin
        k++;
        odd = longint'(2 * k + 1);
      end
      srgb_lut[j] = 8'(k);
    end
  endtask

  // sRGB byte to 16-bit linear light
  function automatic int lin(input logic [7:0] c);
    int v;
    v = int'(c);
    if (v == 0) return 0;
    if (v == 255) return 65535;
    return (v * v * 257 + 128) >>> 8;
  endfunction

  // Glyph dimension after the 1..256 clamp
  function automatic int glyph_extent(input logic [8:0] v);
    int e;
    e = int'(v);
    if (e < 1) e = 1;
    if (e > GLYPH_MAX) e = GLYPH_MAX;
    return e;
  endfunction

  // Expected result for one element; advances the position counters
  function automatic gcgb_pkg::out_item_t blend_elem(input gcgb_pkg::in_item_t it);
    gcgb_pkg::out_item_t r;
    int                  cols, rows, scols, srows, px, py, a, t, b, mix;
    longint              addr;
    r     = '0;
    cols  = glyph_extent(cur_cfg.glyph_cols);
    rows  = glyph_extent(cur_cfg.glyph_rows);
    scols = int'(cur_cfg.surface_cols);
    srows = int'(cur_cfg.surface_rows);
    if (scols > gcgb_pkg::MAX_SURFACE_DIM) scols = gcgb_pkg::MAX_SURFACE_DIM;
    if (srows > gcgb_pkg::MAX_SURFACE_DIM) srows = gcgb_pkg::MAX_SURFACE_DIM;
    px = int'($signed(cur_cfg.origin_x)) + col_cnt;
    py = int'($signed(cur_cfg.origin_y)) + row_cnt;

    // Clip and blend
    if (it.coverage != gcgb_pkg::COV_NONE &&
        px >= 0 && py >= 0 && px < scols && py < srows) begin
      r.write_enable  = 1'b1;
      addr            = longint'(py) * longint'(cur_cfg.row_pitch) + longint'(px);
      r.pixel_address = 25'(addr);
      if (it.coverage == gcgb_pkg::COV_FULL) begin
        r.new_pixel = {gcgb_pkg::ALPHA_OPAQUE, cur_cfg.text_rgb};
      end else begin
        a = int'(it.coverage);
        for (int ch = 0; ch < 3; ch++) begin
          t   = lin(cur_cfg.text_rgb[8*ch +: 8]);
          b   = lin(it.background_pixel[8*ch +: 8]);
          mix = (t * a + b * (255 - a)) / 255;
          r.new_pixel[8*ch +: 8] = srgb_lut[(mix >>> 4) & (LUT_SIZE - 1)];
        end
        r.new_pixel[31:24] = gcgb_pkg::ALPHA_OPAQUE;
      end
    end

    // Position counters; a counter at or past the end counts as the last one
    if (col_cnt + 1 >= cols) begin
      col_cnt = 0;
      if (row_cnt + 1 >= rows) begin
        row_cnt      = 0;
        r.glyph_done = 1'b1;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
    return r;
  endfunction

  // Input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      expected_px.push_back(blend_elem(in_if.data));
      n_accepted++;
    end
  end

  // Result transfers are checked against the oldest expectation
  always @(posedge clk) begin
    gcgb_pkg::out_item_t want;
    gcgb_pkg::out_item_t got;
    logic                bad;
    logic                orphan;
    if (rst_n && out_if.valid && out_if.ready) begin
      got    = out_if.data;
      orphan = 1'b0;
      if (expected_px.size() == 0) begin
        want   = '0;
        bad    = 1'b1;
        orphan = 1'b1;
      end else begin
        want = expected_px.pop_front();
        bad  = (got.write_enable !== want.write_enable) ||
               (got.pixel_address !== want.pixel_address) ||
               (got.new_pixel !== want.new_pixel) ||
               (got.glyph_done !== want.glyph_done);
      end
      if (got.write_enable === 1'b1) n_writes++;
      if (got.glyph_done === 1'b1) n_glyphs++;
      if (bad) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
          $display("%0t: mismatch%s: exp we=%0b addr=%h pix=%h done=%0b",
                   $time, orphan ? " (no expectation)" : "",
                   want.write_enable, want.pixel_address, want.new_pixel, want.glyph_done);
          $display("    got we=%0b addr=%h pix=%h done=%0b",
                   got.write_enable, got.pixel_address, got.new_pixel, got.glyph_done);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic glyph_cfg_t mk_cfg(input int ox, input int oy, input int gc,
                                        input int gr, input int sc, input int sr,
                                        input int pitch, input logic [23:0] rgb);
    glyph_cfg_t c;
    c.origin_x     = 13'(ox);
    c.origin_y     = 13'(oy);
    c.glyph_cols   = 9'(gc);
    c.glyph_rows   = 9'(gr);
    c.surface_cols = 13'(sc);
    c.surface_rows = 13'(sr);
    c.row_pitch    = 14'(pitch);
    c.text_rgb     = rgb;
    return c;
  endfunction

  // Called on a falling edge; returns on a falling edge
  task automatic write_reg(input gcgb_pkg::cfg_idx_t idx,
                           input logic [gcgb_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Block must be idle: all eight registers, back to back
  task automatic program_cfg(input glyph_cfg_t c);
    cfg_we <= 1'b1;
    write_reg(gcgb_pkg::CFG_ORIGIN_X,     gcgb_pkg::CFG_DATA_W'(c.origin_x));
    write_reg(gcgb_pkg::CFG_ORIGIN_Y,     gcgb_pkg::CFG_DATA_W'(c.origin_y));
    write_reg(gcgb_pkg::CFG_GLYPH_COLS,   gcgb_pkg::CFG_DATA_W'(c.glyph_cols));
    write_reg(gcgb_pkg::CFG_GLYPH_ROWS,   gcgb_pkg::CFG_DATA_W'(c.glyph_rows));
    write_reg(gcgb_pkg::CFG_SURFACE_COLS, gcgb_pkg::CFG_DATA_W'(c.surface_cols));
    write_reg(gcgb_pkg::CFG_SURFACE_ROWS, gcgb_pkg::CFG_DATA_W'(c.surface_rows));
    write_reg(gcgb_pkg::CFG_ROW_PITCH,    gcgb_pkg::CFG_DATA_W'(c.row_pitch));
    write_reg(gcgb_pkg::CFG_TEXT_RGB,     gcgb_pkg::CFG_DATA_W'(c.text_rgb));
    cfg_we  <= 1'b0;
    cur_cfg  = c;
    n_cfg++;
  endtask

  // One input transfer with an optional random gap in front; valid stays up afterwards
  task automatic send_elem(input logic [7:0] cov, input logic [31:0] bg);
    while ($urandom_range(99) < send_idle_pct) begin
      gcgb_pkg::in_item_t idle_item;
      idle_item.coverage         = 8'($urandom);
      idle_item.background_pixel = $urandom;
      in_if.valid <= 1'b0;
      in_if.data  <= idle_item;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{coverage: cov, background_pixel: bg};
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    n_sent++;
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_cov();
    case ($urandom_range(7))
      0:       return gcgb_pkg::COV_NONE;
      1:       return gcgb_pkg::COV_FULL;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic glyph_cfg_t rand_cfg();
    glyph_cfg_t c;
    // Mostly small glyphs; now and then a wide one, clamp range included
    if ($urandom_range(9) == 0) begin
      c.glyph_cols = 9'($urandom);
      c.glyph_rows = 9'($urandom_range(1));
    end else begin
      c.glyph_cols = 9'($urandom_range(12, 1));
      c.glyph_rows = 9'($urandom_range(6, 1));
    end
    // Either the full register range or a small surface with the glyph near its edges
    if ($urandom_range(4) == 0) begin
      c.origin_x     = 13'($urandom);
      c.origin_y     = 13'($urandom);
      c.surface_cols = 13'($urandom);
      c.surface_rows = 13'($urandom);
    end else begin
      c.origin_x     = 13'($urandom_range(24)) - 13'd6;
      c.origin_y     = 13'($urandom_range(12)) - 13'd4;
      c.surface_cols = 13'($urandom_range(24));
      c.surface_rows = 13'($urandom_range(12));
    end
    c.row_pitch = ($urandom_range(2) == 0) ? 14'($urandom) : 14'($urandom_range(64));
    case ($urandom_range(5))
      0:       c.text_rgb = 24'h000000;
      1:       c.text_rgb = 24'hFFFFFF;
      default: c.text_rgb = 24'($urandom);
    endcase
    return c;
  endfunction

  // Default registers: surface of zero size, so nothing is written
  task automatic test_after_reset();
    send_elem(gcgb_pkg::COV_FULL, 32'hFFFF_FFFF);
    send_elem(8'd128,             32'h1234_5678);
    send_elem(gcgb_pkg::COV_NONE, 32'h0000_0000);
  endtask

  // Shrinking the glyph while the column counter is already past its new end
  task automatic test_counter_past_end();
    wait_drain();
    program_cfg(mk_cfg(0, 0, 2, 2, 16, 16, 16, 24'h123456));
    for (int i = 0; i < 5; i++) send_elem(8'd200, 32'h80C0_4020);
  endtask

  // Coverage and color extremes on a clamped, max-pitch surface
  task automatic test_blend_extremes();
    wait_drain();
    program_cfg(mk_cfg(0, 0, 3, 2, 8191, 8191, 16383, 24'hFFFFFF));
    send_elem(gcgb_pkg::COV_NONE, 32'hFFFF_FFFF);
    send_elem(gcgb_pkg::COV_FULL, 32'h0000_0000);
    send_elem(8'd1,               32'h0000_0000);
    send_elem(8'd254,             32'hFFFF_FFFF);
    send_elem(8'd128,             32'h00FF_00FF);
    send_elem(8'd64,              32'hFF00_FF00);
  endtask

  // Glyph hanging over the top-left corner of a 1x1 surface
  task automatic test_clip_edges();
    wait_drain();
    program_cfg(mk_cfg(-1, -1, 3, 3, 1, 1, 7, 24'h000000));
    for (int i = 0; i < 9; i++) send_elem(8'd200, 32'hFF80_4010);
  endtask

  // Origin extremes, zero glyph size clamped to one, address wraparound
  task automatic test_origin_extremes();
    wait_drain();
    program_cfg(mk_cfg(4095, -4096, 0, 0, 4096, 4096, 100, 24'h00FF00));
    send_elem(gcgb_pkg::COV_FULL, 32'h0000_0000);
    wait_drain();
    program_cfg(mk_cfg(4095, 4095, 0, 0, 8191, 8191, 16383, 24'h0000FF));
    send_elem(8'd77, 32'hFF11_2233);
  endtask

  // Whole glyphs with random content, some broken ones, one mid-glyph drain
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_target);
    glyph_cfg_t c;
    int         start, len, glyph_len;
    bit         held;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = n_sent;
    held           = 1'b0;
    while (n_sent - start < n_target) begin
      wait_drain();
      c = rand_cfg();
      program_cfg(c);
      glyph_len = glyph_extent(c.glyph_cols) * glyph_extent(c.glyph_rows);
      if ($urandom_range(7) == 0) len = $urandom_range(glyph_len, 1);
      else if (glyph_len > 64) len = glyph_len;
      else len = glyph_len * $urandom_range(3, 1);
      for (int i = 0; i < len; i++) begin
        if (!held && n_sent - start >= n_target / 2) begin
          wait_drain();
          held = 1'b1;
        end
        send_elem(rand_cov(), $urandom);
      end
    end
  endtask

  initial begin
    build_srgb_lut();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = gcgb_pkg::CFG_ORIGIN_X;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_sent         = 0;
    n_accepted     = 0;
    n_writes       = 0;
    n_glyphs       = 0;
    n_cfg          = 0;
    n_mismatch     = 0;
    col_cnt        = 0;
    row_cnt        = 0;
    cur_cfg        = mk_cfg(0, 0, gcgb_pkg::GLYPH_COLS_RST, gcgb_pkg::GLYPH_ROWS_RST,
                            0, 0, 0, 24'h000000);
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_after_reset();
    test_counter_past_end();
    test_blend_extremes();
    test_clip_edges();
    test_origin_extremes();

    run_random_phase(0,  0,  PHASE_ITEMS);
    run_random_phase(83, 0,  PHASE_ITEMS);
    run_random_phase(0,  83, PHASE_ITEMS);
    run_random_phase(18, 18, PHASE_ITEMS);

    // Drain, then watch a while for stray results
    wait_drain();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Run covered %0d elements over %0d register settings and four idle mixes:",
             n_accepted, n_cfg);
    $display("  %0d pixel writes, %0d completed glyphs, %0d mismatches",
             n_writes, n_glyphs, n_mismatch);
    if (n_mismatch == 0 && expected_px.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
